// ----- hdl/hll_pkg.sv -----
// ----------------------------------------------------------------------------
// hll_pkg
// shared constants, codes, state type and hash helpers for the hyperloglog
// sketch update unit
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int INDEX_BITS_DEF = 10;

  localparam int OP_W        = 2;
  localparam int KEY_BYTE_W  = 8;
  localparam int READ_IDX_W  = 10;
  localparam int REG_IDX_W   = 10;
  localparam int RHO_W       = 5;
  localparam int HASH_W      = 32;
  localparam int COUNT_W     = 32;

  localparam logic [OP_W-1:0] OP_KEY_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_END_KEY  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  localparam logic KIND_UPDATE   = 1'b0;
  localparam logic KIND_READBACK = 1'b1;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;
  localparam logic [HASH_W-1:0] MIX_MUL_A = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] MIX_MUL_B = 32'hc2b2ae35;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX,
    ST_LOOK,
    ST_UPD,
    ST_RDOUT
  } hll_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } hll_mem_ctl_t;

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [KEY_BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-KEY_BYTE_W){1'b0}}, b};
    return x * FNV_PRIME;
  endfunction

  function automatic logic [HASH_W-1:0] xor_shift(input logic [HASH_W-1:0] h,
                                                  input int unsigned sh);
    return h ^ (h >> sh);
  endfunction

endpackage

// ----- hdl/hll_in_if.sv -----
// ----------------------------------------------------------------------------
// hll_in_if
// input channel: key bytes, end-of-key marks and register reads
// ----------------------------------------------------------------------------
interface hll_in_if import hll_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [KEY_BYTE_W-1:0] key_byte;
  logic [READ_IDX_W-1:0] read_index;

  modport source (output valid, op, key_byte, read_index, input ready);
  modport sink   (input valid, op, key_byte, read_index, output ready);

endinterface

// ----- hdl/hll_out_if.sv -----
// ----------------------------------------------------------------------------
// hll_out_if
// result channel: update results and register readback
// ----------------------------------------------------------------------------
interface hll_out_if import hll_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [REG_IDX_W-1:0] reg_index;
  logic [RHO_W-1:0]     rho_value;
  logic [RHO_W-1:0]     reg_value;
  logic                 changed;
  logic [HASH_W-1:0]    hash_value;
  logic [COUNT_W-1:0]   key_count;

  modport source (output valid, kind, reg_index, rho_value, reg_value, changed,
                  hash_value, key_count, input ready);
  modport sink   (input valid, kind, reg_index, rho_value, reg_value, changed,
                  hash_value, key_count, output ready);

endinterface

// ----- hdl/hyperloglog_sketch_update_unit.sv -----
// ----------------------------------------------------------------------------
// hyperloglog_sketch_update_unit
// folds key bytes into an fnv-1a hash, finalizes it, and raises the selected
// sketch register to the key's rank; also reads back single registers
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_ch    in   valid / ready        op, key_byte, read_index
//  out_ch   out  valid / ready        kind, reg_index, rho_value, reg_value,
//                                     changed, hash_value, key_count
//
//  key byte: bytes may follow every cycle while the unit is idle (one constant multiply)
//  end of key: two mix multiplies, sketch read, compare and write
//  register read: registered sketch read plus result load
//  after reset a clearing pass zeroes all 2**INDEX_BITS sketch registers, with
//  in_ch.ready low
//  the result register frees the core once loaded; the core waits in its last
//  step only while a previous beat is still held on out_ch
// ----------------------------------------------------------------------------
module hyperloglog_sketch_update_unit import hll_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hll_in_if.sink    in_ch,
  hll_out_if.source out_ch
);

  localparam int RANK_BITS = HASH_W - INDEX_BITS;

  hll_state_t state_r, state_nxt;

  logic [HASH_W-1:0]     accum_r;
  logic [HASH_W-1:0]     mix_r;
  logic [HASH_W-1:0]     hash_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [INDEX_BITS-1:0] clr_cnt_r;
  logic [COUNT_W-1:0]    keys_r;

  logic                  out_valid_r;
  logic                  kind_r;
  logic [REG_IDX_W-1:0]  reg_index_r;
  logic [RHO_W-1:0]      rho_value_r;
  logic [RHO_W-1:0]      reg_value_r;
  logic                  changed_r;
  logic [HASH_W-1:0]     hash_value_r;
  logic [COUNT_W-1:0]    key_count_r;

  logic                  in_ready;
  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  hll_mem_ctl_t          mem_ctl;
  logic [INDEX_BITS-1:0] rd_addr;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [RHO_W-1:0]      wr_data;
  logic [RHO_W-1:0]      rd_data;
  logic [HASH_W-1:0]     hash_fin;
  logic [INDEX_BITS-1:0] read_idx;
  logic [RANK_BITS-1:0]  rank_word;
  logic [RHO_W-1:0]      rho;
  logic                  raise;
  logic [RHO_W-1:0]      new_val;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign read_idx = INDEX_BITS'(in_ch.read_index);
  assign hash_fin = xor_shift(mix_r, 16);

  // rank over the bits above the index
  assign rank_word = hash_r[HASH_W-1:INDEX_BITS];

  always_comb begin
    rho = RHO_W'(RANK_BITS);
    for (int i = 0; i < RANK_BITS; i++) begin
      if (rank_word[i]) begin
        rho = RHO_W'(RANK_BITS - i);
      end
    end
  end

  assign raise   = rho > rd_data;
  assign new_val = raise ? rho : rd_data;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and control
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    mem_ctl.rd_en  = 1'b0;
    mem_ctl.wr_en  = 1'b0;
    rd_addr        = read_idx;
    wr_addr        = idx_r;
    wr_data        = new_val;
    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = clr_cnt_r;
        wr_data       = '0;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          priority case (in_ch.op)
            OP_END_KEY: state_nxt = ST_MIX;
            OP_READ: begin
              mem_ctl.rd_en = 1'b1;
              state_nxt     = ST_RDOUT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MIX: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = hash_fin[INDEX_BITS-1:0];
        state_nxt     = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          out_load      = 1'b1;
          mem_ctl.wr_en = raise;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= FNV_BASIS;
      keys_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (in_fire && in_ch.op == OP_KEY_BYTE) begin
        accum_r <= fnv_step(accum_r, in_ch.key_byte);
      end else if (in_fire && in_ch.op == OP_END_KEY) begin
        accum_r <= FNV_BASIS;
        if (keys_r != '1) begin
          keys_r <= keys_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.op == OP_END_KEY) begin
      mix_r <= xor_shift(accum_r, 16) * MIX_MUL_A;
    end else if (state_r == ST_MIX) begin
      mix_r <= xor_shift(mix_r, 13) * MIX_MUL_B;
    end
    if (state_r == ST_LOOK) begin
      hash_r <= hash_fin;
      idx_r  <= hash_fin[INDEX_BITS-1:0];
    end else if (in_fire && in_ch.op == OP_READ) begin
      idx_r <= read_idx;
    end
    if (out_load) begin
      reg_index_r <= REG_IDX_W'(idx_r);
      reg_value_r <= (state_r == ST_UPD) ? new_val : rd_data;
      key_count_r <= keys_r;
      if (state_r == ST_UPD) begin
        kind_r       <= KIND_UPDATE;
        rho_value_r  <= rho;
        changed_r    <= raise;
        hash_value_r <= hash_r;
      end else begin
        kind_r       <= KIND_READBACK;
        rho_value_r  <= '0;
        changed_r    <= 1'b0;
        hash_value_r <= '0;
      end
    end
  end

  hll_sketch_ram #(
    .ADDR_BITS (INDEX_BITS)
  ) u_ram (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.reg_index  = reg_index_r;
  assign out_ch.rho_value  = rho_value_r;
  assign out_ch.reg_value  = reg_value_r;
  assign out_ch.changed    = changed_r;
  assign out_ch.hash_value = hash_value_r;
  assign out_ch.key_count  = key_count_r;

`ifndef SYNTH
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ch.ready)
    else $error("input taken during clearing pass");

  a_write_only_update_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (state_r == ST_UPD || state_r == ST_CLEAR))
    else $error("sketch written outside update or clear");

  a_update_keeps_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_UPDATE |-> reg_value_r >= rho_value_r)
    else $error("update result below rank");

  a_changed_means_rho: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && changed_r |-> reg_value_r == rho_value_r)
    else $error("raised register differs from rank");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(hash_value_r) && $stable(reg_value_r))
    else $error("held result beat overwritten");
`endif

endmodule

// ----- hdl/hll_sketch_ram.sv -----
// ----------------------------------------------------------------------------
// hll_sketch_ram
// sketch register store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module hll_sketch_ram import hll_pkg::*; #(
  parameter int ADDR_BITS = INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  hll_mem_ctl_t         ctl,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [RHO_W-1:0]     rd_data,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [RHO_W-1:0]     wr_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [RHO_W-1:0] mem [DEPTH];
  logic [RHO_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hyperloglog sketch update unit: drives key
// bytes, end-of-key marks and register reads with random pacing on both
// channels, keeps a shadow copy of the hash, sketch and key count, and checks
// every result beat field by field in order
// ----------------------------------------------------------------------------
module tb_top;
  import hll_pkg::*;

  localparam int IDX_BITS  = INDEX_BITS_DEF;
  localparam int NREGS     = 1 << IDX_BITS;
  localparam int RANK_BITS = 32 - IDX_BITS;
  localparam int QUIET_MAX = 5000;
  localparam int DRAIN_CYC = 20;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic                 kind;
    logic [REG_IDX_W-1:0] reg_index;
    logic [RHO_W-1:0]     rho_value;
    logic [RHO_W-1:0]     reg_value;
    logic                 changed;
    logic [HASH_W-1:0]    hash_value;
    logic [COUNT_W-1:0]   key_count;
  } sketch_result_t;

  logic clk;
  logic rst_n;

  hll_in_if  in_ch ();
  hll_out_if out_ch ();

  hyperloglog_sketch_update_unit #(
    .INDEX_BITS(IDX_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow state of the sketch
  logic [HASH_W-1:0]  shadow_accum;
  logic [RHO_W-1:0]   shadow_regs [NREGS];
  logic [COUNT_W-1:0] shadow_keys;

  sketch_result_t        awaited_results [$];
  logic [READ_IDX_W-1:0] touched_regs [$];
  logic [7:0]            last_key [$];

  int mismatch_count = 0;
  bit src_steady     = 1'b0;
  bit sink_steady    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] finalize_hash(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 16);
    x = x * MIX_MUL_A;
    x = x ^ (x >> 13);
    x = x * MIX_MUL_B;
    return x ^ (x >> 16);
  endfunction

  function automatic logic [31:0] mod_inverse(input logic [31:0] a);
    logic [31:0] x;
    x = a;
    repeat (5) x = x * (32'd2 - a * x);
    return x;
  endfunction

  // undoes finalize_hash step by step
  function automatic logic [31:0] unmix(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 16);
    x = x * mod_inverse(MIX_MUL_B);
    x = x ^ (x >> 13) ^ (x >> 26);
    x = x * mod_inverse(MIX_MUL_A);
    return x ^ (x >> 16);
  endfunction

  function automatic logic [RHO_W-1:0] rank_of(input logic [31:0] h);
    logic [31:0] w;
    int          zeros;
    bit          seen;
    w     = h >> IDX_BITS;
    zeros = 0;
    seen  = 1'b0;
    for (int b = RANK_BITS - 1; b >= 0; b--) begin
      if (!seen) begin
        if (w[b]) seen = 1'b1;
        else zeros++;
      end
    end
    if (zeros + 1 > RANK_BITS) return RHO_W'(RANK_BITS);
    return RHO_W'(zeros + 1);
  endfunction

  function automatic void fold_beat(input logic [OP_W-1:0] op, input logic [7:0] b,
                                    input logic [READ_IDX_W-1:0] ridx);
    sketch_result_t      r;
    logic [31:0]         h;
    logic [IDX_BITS-1:0] idx;
    logic [RHO_W-1:0]    rho;
    case (op)
      OP_KEY_BYTE: shadow_accum = fnv_fold(shadow_accum, b);
      OP_END_KEY: begin
        h   = finalize_hash(shadow_accum);
        idx = h[IDX_BITS-1:0];
        rho = rank_of(h);
        shadow_accum = FNV_BASIS;
        if (shadow_keys != '1) shadow_keys++;
        r.kind       = KIND_UPDATE;
        r.reg_index  = REG_IDX_W'(idx);
        r.rho_value  = rho;
        r.changed    = rho > shadow_regs[idx];
        if (r.changed) shadow_regs[idx] = rho;
        r.reg_value  = shadow_regs[idx];
        r.hash_value = h;
        r.key_count  = shadow_keys;
        awaited_results.push_back(r);
        touched_regs.push_back(READ_IDX_W'(idx));
        if (touched_regs.size() > 32) void'(touched_regs.pop_front());
      end
      OP_READ: begin
        idx = IDX_BITS'(ridx);
        r.kind       = KIND_READBACK;
        r.reg_index  = REG_IDX_W'(idx);
        r.rho_value  = '0;
        r.reg_value  = shadow_regs[idx];
        r.changed    = 1'b0;
        r.hash_value = '0;
        r.key_count  = shadow_keys;
        awaited_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic push_beat(input logic [OP_W-1:0] op, input logic [7:0] b,
                           input logic [READ_IDX_W-1:0] ridx);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.key_byte   <= b;
    in_ch.read_index <= ridx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fold_beat(op, b, ridx);
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_beat(OP_KEY_BYTE, b, READ_IDX_W'($urandom_range(0, NREGS - 1)));
  endtask

  task automatic send_end();
    push_beat(OP_END_KEY, 8'($urandom_range(0, 255)),
              READ_IDX_W'($urandom_range(0, NREGS - 1)));
  endtask

  task automatic send_read(input logic [READ_IDX_W-1:0] ridx);
    push_beat(OP_READ, 8'($urandom_range(0, 255)), ridx);
  endtask

  task automatic send_noise();
    push_beat(OP_UNUSED, 8'($urandom_range(0, 255)),
              READ_IDX_W'($urandom_range(0, NREGS - 1)));
  endtask

  task automatic test_empty_key();
    send_end();
    send_read(touched_regs[$]);
  endtask

  task automatic test_edge_bytes();
    send_byte(8'h00);
    send_end();
    send_byte(8'hff);
    send_end();
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(8'hff);
    send_end();
    send_read('0);
    send_read('1);
  endtask

  task automatic test_ignored_code();
    send_byte(8'h12);
    send_noise();
    send_end();
    send_read(touched_regs[$]);
  endtask

  // meet in the middle over a four-byte key whose hash has all rank bits zero
  task automatic test_rank_cap();
    logic [15:0] pair_of [logic [31:0]];
    logic [31:0] pinv;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  key [4];
    logic [31:0] target;
    bit          found;
    found = 1'b0;
    pinv  = mod_inverse(FNV_PRIME);
    for (int b0 = 0; b0 < 256; b0++) begin
      for (int b1 = 0; b1 < 256; b1++) begin
        pair_of[fnv_fold(fnv_fold(FNV_BASIS, 8'(b0)), 8'(b1))] = {8'(b0), 8'(b1)};
      end
    end
    for (int t = 0; t < 64 && !found; t++) begin
      x = unmix(32'(t)) * pinv;
      for (int b3 = 0; b3 < 256 && !found; b3++) begin
        y = (x ^ 32'(b3)) * pinv;
        for (int b2 = 0; b2 < 256 && !found; b2++) begin
          if (pair_of.exists(y ^ 32'(b2))) begin
            {key[0], key[1]} = pair_of[y ^ 32'(b2)];
            key[2] = 8'(b2);
            key[3] = 8'(b3);
            target = 32'(t);
            found  = 1'b1;
          end
        end
      end
    end
    if (found) begin
      repeat (2) begin
        for (int i = 0; i < 4; i++) send_byte(key[i]);
        send_end();
      end
      send_read(target[READ_IDX_W-1:0]);
    end else begin
      $display("%0t note: no key with a capped rank was found", $time);
    end
  endtask

  task automatic test_random_traffic();
    int items;
    int next_flip;
    int len;
    int r;
    items     = 0;
    next_flip = 0;
    while (items < 800) begin
      if (items >= next_flip) begin
        next_flip   = next_flip + 100;
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r = $urandom_range(0, 9);
        if (r == 0) len = 0;
        else if (r == 9) len = $urandom_range(7, 16);
        else len = $urandom_range(1, 6);
        last_key.delete();
        for (int i = 0; i < len; i++) begin
          last_key.push_back(8'($urandom_range(0, 255)));
          send_byte(last_key[$]);
          if ($urandom_range(0, 19) == 0) send_noise();
        end
        send_end();
        items = items + len + 1;
      end else if (r < 85) begin
        if (touched_regs.size() > 0 && $urandom_range(0, 1) == 0)
          send_read(touched_regs[$urandom_range(0, touched_regs.size() - 1)]);
        else
          send_read(READ_IDX_W'($urandom_range(0, NREGS - 1)));
        items++;
      end else if (r < 95) begin
        // same key again: the register must not move
        foreach (last_key[i]) send_byte(last_key[i]);
        send_end();
        items = items + last_key.size() + 1;
      end else begin
        send_noise();
      end
    end
  endtask

  // result sink pacing
  initial begin : sink_pacing
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      if (sink_steady || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 12);
      end else begin
        out_ch.ready <= 1'b0;
        n = 1 + pick_gap();
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    sketch_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected beat expected none actual kind %0d index %0d hash %h",
                 $time, out_ch.kind, out_ch.reg_index, out_ch.hash_value);
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_ch.kind));
        check_field("reg_index", 32'(want.reg_index), 32'(out_ch.reg_index));
        check_field("rho_value", 32'(want.rho_value), 32'(out_ch.rho_value));
        check_field("reg_value", 32'(want.reg_value), 32'(out_ch.reg_value));
        check_field("changed", 32'(want.changed), 32'(out_ch.changed));
        check_field("hash_value", want.hash_value, out_ch.hash_value);
        check_field("key_count", want.key_count, out_ch.key_count);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_KEY_BYTE;
    in_ch.key_byte   <= '0;
    in_ch.read_index <= '0;
    shadow_accum = FNV_BASIS;
    shadow_keys  = '0;
    for (int i = 0; i < NREGS; i++) shadow_regs[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_key();
    test_edge_bytes();
    test_ignored_code();
    test_rank_cap();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/hll_pkg.sv
hdl/hll_in_if.sv
hdl/hll_out_if.sv
hdl/hll_sketch_ram.sv
hdl/hyperloglog_sketch_update_unit.sv
sim/tb_top.sv
